### design/voxel_grid_ray_traversal_top_macros.svh
// ----------------------------------------------------------------------------
// Voxel grid ray traversal: assertion macros
// Shorthand for the clocked checks used inside the design modules.
// ----------------------------------------------------------------------------
`ifndef VOXEL_GRID_RAY_TRAVERSAL_TOP_MACROS_SVH
`define VOXEL_GRID_RAY_TRAVERSAL_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define VGRT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vgrt check failed");

// next-cycle implication, checked out of reset
`define VGRT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vgrt check failed");

`endif

### design/vgrt_pkg.sv
// ----------------------------------------------------------------------------
// Voxel grid ray traversal package
// Shared widths, codes and the queue item type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vgrt_pkg;

    localparam int GRID_SIZE_DEF   = 16;
    localparam int QUEUE_DEPTH_DEF = 2;

    // datapath widths
    localparam int LOC_W     = 30;          // local origin, Q.8
    localparam int CELL_W    = LOC_W - 8;   // signed cell coordinate
    localparam int ORG_W     = 24;
    localparam int DIR_W     = 16;
    localparam int DIST_W    = 9;           // first boundary distance, Q.8, up to 256
    localparam int MAG_W     = 16;          // direction magnitude, up to 32768
    localparam int NUM_W     = 31;          // dividend width
    localparam int REM_W     = MAG_W + 1;
    localparam int T_W       = 32;          // boundary time, Q16.16
    localparam int LIM_W     = 24;
    localparam int IDX_W     = 12;
    localparam int CHUNK_W   = 12;
    localparam int MAXD_W    = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [T_W-1:0]   T_SAT    = '1;
    localparam logic [NUM_W-1:0] NUM_STEP = {1'b1, {(NUM_W-1){1'b0}}};  // 2^30

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_Z = 2'd2;

    // item kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_CAST  = 1'b1;

    // result status
    localparam logic [1:0] ST_HIT  = 2'd0;
    localparam logic [1:0] ST_FAR  = 2'd1;
    localparam logic [1:0] ST_LEFT = 2'd2;
    localparam logic [1:0] ST_ZERO = 2'd3;

    // face normal codes
    localparam logic [1:0] NORM_NONE = 2'b00;
    localparam logic [1:0] NORM_POS  = 2'b01;
    localparam logic [1:0] NORM_NEG  = 2'b11;

    typedef struct packed {
        logic signed [CELL_W-1:0] start_cell;
        logic [DIST_W-1:0]        bnd_dist;
        logic [MAG_W-1:0]         mag;
        logic                     neg;
        logic                     zero;
    } axis_t;

    typedef struct packed {
        logic                kind;
        logic [IDX_W-1:0]    voxel_index;
        logic                solid;
        logic [MAXD_W-1:0]   max_distance;
        logic                zero_dir;
        axis_t [2:0]         axis;
    } item_t;

endpackage

### design/vgrt_req_if.sv
// ----------------------------------------------------------------------------
// Voxel grid ray traversal request channel
// Write and cast items, valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface vgrt_req_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic [11:0]        voxel_index;
    logic               solid;
    logic signed [23:0] origin_x;
    logic signed [23:0] origin_y;
    logic signed [23:0] origin_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic [15:0]        max_distance;

    modport source (
        output valid, kind, voxel_index, solid, origin_x, origin_y, origin_z,
               dir_x, dir_y, dir_z, max_distance,
        input  ready
    );
    modport sink (
        input  valid, kind, voxel_index, solid, origin_x, origin_y, origin_z,
               dir_x, dir_y, dir_z, max_distance,
        output ready
    );
endinterface

### design/vgrt_rsp_if.sv
// ----------------------------------------------------------------------------
// Voxel grid ray traversal result channel
// One result item per cast, valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface vgrt_rsp_if;
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [3:0]        hit_x;
    logic [3:0]        hit_y;
    logic [3:0]        hit_z;
    logic signed [1:0] normal_x;
    logic signed [1:0] normal_y;
    logic signed [1:0] normal_z;

    modport source (
        output valid, status, hit_x, hit_y, hit_z, normal_x, normal_y, normal_z,
        input  ready
    );
    modport sink (
        input  valid, status, hit_x, hit_y, hit_z, normal_x, normal_y, normal_z,
        output ready
    );
endinterface

### design/voxel_grid_ray_traversal_top.sv
// ----------------------------------------------------------------------------
// Voxel grid ray traversal top level
// Occupancy map of GRID_SIZE^3 voxels with a 3D DDA ray caster.
// ----------------------------------------------------------------------------
// After reset the map is cleared one voxel per cycle; the back part takes no
// item during that pass (the queue still accepts up to two), but chunk
// register writes are taken. A write item is stored in the map when it is
// popped. A cast is dispatched from idle, then waits on the per-axis
// restoring dividers (31 quotient bits, then the load of the first and step
// boundary times), then visits each cell in a map read state and then in
// a compare and step state, and ends when a result is loaded. A
// zero-direction cast finishes at dispatch. A two-entry queue decouples
// item intake from the back part, and the result register lets the next
// item start while a result waits.
`timescale 1ns / 1ps

module voxel_grid_ray_traversal_top #(
    parameter int GRID_SIZE   = vgrt_pkg::GRID_SIZE_DEF,
    parameter int QUEUE_DEPTH = vgrt_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [vgrt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [vgrt_pkg::CHUNK_W-1:0]    cfg_data,
    vgrt_req_if.sink                        req,
    vgrt_rsp_if.source                      rsp
);
    vgrt_pkg::item_t front_item, queue_item;
    logic            front_valid, front_ready;
    logic            queue_valid, queue_pop;

    vgrt_front #(.GRID_SIZE(GRID_SIZE)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .req        (req),
        .item       (front_item),
        .item_valid (front_valid),
        .item_ready (front_ready)
    );

    vgrt_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_item  (front_item),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_item   (queue_item),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_pop)
    );

    vgrt_back #(.GRID_SIZE(GRID_SIZE)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (queue_item),
        .item_valid (queue_valid),
        .item_pop   (queue_pop),
        .rsp        (rsp)
    );

endmodule

### design/vgrt_div.sv
// ----------------------------------------------------------------------------
// Voxel grid ray traversal divider
// Restoring divider, one quotient bit per cycle, two dividends over one divisor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vgrt_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [vgrt_pkg::NUM_W-1:0]  num_a,
    input  logic [vgrt_pkg::NUM_W-1:0]  num_b,
    input  logic [vgrt_pkg::MAG_W-1:0]  den,
    output logic                        busy,
    output logic [vgrt_pkg::NUM_W-1:0]  quo_a,
    output logic [vgrt_pkg::NUM_W-1:0]  quo_b
);
    localparam int NUM_W = vgrt_pkg::NUM_W;
    localparam int REM_W = vgrt_pkg::REM_W;
    localparam int CNT_W = $clog2(NUM_W);

    logic                busy_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [REM_W-1:0]    rem_a_reg, rem_b_reg;
    logic [NUM_W-1:0]    sh_a_reg, sh_b_reg;
    logic [REM_W-1:0]    den_reg;
    logic [REM_W-1:0]    try_a, try_b;
    logic                ge_a, ge_b;

    // one restoring step per dividend
    always_comb
    begin
        try_a = {rem_a_reg[REM_W-2:0], sh_a_reg[NUM_W-1]};
        try_b = {rem_b_reg[REM_W-2:0], sh_b_reg[NUM_W-1]};
        ge_a  = try_a >= den_reg;
        ge_b  = try_b >= den_reg;
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(NUM_W - 1);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
                busy_reg <= 1'b0;
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // shift registers: dividend bits leave at the top, quotient bits enter below
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_a_reg <= '0;
            rem_b_reg <= '0;
            sh_a_reg  <= num_a;
            sh_b_reg  <= num_b;
            den_reg   <= {1'b0, den};
        end
        else if (busy_reg)
        begin
            rem_a_reg <= ge_a ? try_a - den_reg : try_a;
            rem_b_reg <= ge_b ? try_b - den_reg : try_b;
            sh_a_reg  <= {sh_a_reg[NUM_W-2:0], ge_a};
            sh_b_reg  <= {sh_b_reg[NUM_W-2:0], ge_b};
        end
    end

    assign busy  = busy_reg;
    assign quo_a = sh_a_reg;
    assign quo_b = sh_b_reg;

endmodule

### design/vgrt_fifo.sv
// ----------------------------------------------------------------------------
// Voxel grid ray traversal queue
// Short item queue between the front and back parts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vgrt_fifo #(
    parameter int DEPTH = vgrt_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  vgrt_pkg::item_t push_item,
    input  logic            push_valid,
    output logic            push_ready,
    output vgrt_pkg::item_t pop_item,
    output logic            pop_valid,
    input  logic            pop_ready
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    vgrt_pkg::item_t  slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push, do_pop;

    assign push_ready = count_reg != CW'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_ready && pop_valid;

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

endmodule

### design/vgrt_front.sv
// ----------------------------------------------------------------------------
// Voxel grid ray traversal front part
// Holds the chunk registers, moves the origin into chunk space and
// classifies each axis (start cell, first boundary distance, magnitude).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vgrt_front #(
    parameter int GRID_SIZE = vgrt_pkg::GRID_SIZE_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [vgrt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [vgrt_pkg::CHUNK_W-1:0]    cfg_data,
    vgrt_req_if.sink                        req,
    output vgrt_pkg::item_t                 item,
    output logic                            item_valid,
    input  logic                            item_ready
);
    localparam int LOC_W   = vgrt_pkg::LOC_W;
    localparam int ORG_W   = vgrt_pkg::ORG_W;
    localparam int DIR_W   = vgrt_pkg::DIR_W;
    localparam int CHUNK_W = vgrt_pkg::CHUNK_W;
    localparam int DIST_W  = vgrt_pkg::DIST_W;
    localparam int MAG_W   = vgrt_pkg::MAG_W;
    localparam logic signed [LOC_W-1:0] OFF_MUL = LOC_W'(GRID_SIZE * 256);

    logic signed [CHUNK_W-1:0] chunk_reg [3];
    logic signed [ORG_W-1:0]   org [3];
    logic signed [DIR_W-1:0]   dir [3];
    logic signed [LOC_W-1:0]   loc [3];
    logic [7:0]                frac [3];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_reg[0] <= '0;
            chunk_reg[1] <= '0;
            chunk_reg[2] <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                vgrt_pkg::CFG_CHUNK_X: chunk_reg[0] <= cfg_data;
                vgrt_pkg::CFG_CHUNK_Y: chunk_reg[1] <= cfg_data;
                vgrt_pkg::CFG_CHUNK_Z: chunk_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    assign org[0] = req.origin_x;
    assign org[1] = req.origin_y;
    assign org[2] = req.origin_z;
    assign dir[0] = req.dir_x;
    assign dir[1] = req.dir_y;
    assign dir[2] = req.dir_z;

    // per-axis setup: local origin, start cell, first boundary distance
    always_comb
    begin
        item.kind         = req.kind;
        item.voxel_index  = req.voxel_index;
        item.solid        = req.solid;
        item.max_distance = req.max_distance;
        item.zero_dir     = (dir[0] == '0) && (dir[1] == '0) && (dir[2] == '0);
        for (int a = 0; a < 3; a++)
        begin
            loc[a]  = {{(LOC_W-ORG_W){org[a][ORG_W-1]}}, org[a]}
                    - {{(LOC_W-CHUNK_W){chunk_reg[a][CHUNK_W-1]}}, chunk_reg[a]} * OFF_MUL;
            frac[a] = loc[a][7:0];
            item.axis[a].start_cell = loc[a][LOC_W-1:8];
            item.axis[a].neg  = dir[a][DIR_W-1];
            item.axis[a].zero = dir[a] == '0;
            item.axis[a].mag  = dir[a][DIR_W-1] ? MAG_W'(-dir[a]) : MAG_W'(dir[a]);
            if (dir[a][DIR_W-1])
                item.axis[a].bnd_dist = (frac[a] == '0) ? DIST_W'(256) : {1'b0, frac[a]};
            else
                item.axis[a].bnd_dist = DIST_W'(256) - {1'b0, frac[a]};
        end
    end

    assign item_valid = req.valid;
    assign req.ready  = item_ready;

endmodule

### design/vgrt_back.sv
// ----------------------------------------------------------------------------
// Voxel grid ray traversal back part
// Owns the occupancy map, runs the boundary-time divides and steps the DDA,
// visiting each cell in a map read state, then a compare and step state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "voxel_grid_ray_traversal_top_macros.svh"

module vgrt_back #(
    parameter int GRID_SIZE = vgrt_pkg::GRID_SIZE_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  vgrt_pkg::item_t item,
    input  logic            item_valid,
    output logic            item_pop,
    vgrt_rsp_if.source      rsp
);
    localparam int CELLS  = GRID_SIZE * GRID_SIZE * GRID_SIZE;
    localparam int AW     = $clog2(CELLS);
    localparam int CELL_W = vgrt_pkg::CELL_W;
    localparam int T_W    = vgrt_pkg::T_W;
    localparam int NUM_W  = vgrt_pkg::NUM_W;
    localparam int DIST_W = vgrt_pkg::DIST_W;
    localparam int LIM_W  = vgrt_pkg::LIM_W;
    localparam logic [AW-1:0] CLR_LAST = AW'(CELLS - 1);
    localparam logic signed [CELL_W-1:0] GRID_HI = CELL_W'(GRID_SIZE);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;

    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    logic                     solid_map [CELLS];
    logic [2:0]               state_reg;
    logic [AW-1:0]            clr_cnt_reg;
    logic signed [CELL_W-1:0] cell_reg [3];
    logic [T_W-1:0]           t_reg [3];
    logic [T_W-1:0]           dt_reg [3];
    logic                     neg_reg [3];
    logic                     zero_reg [3];
    logic [1:0]               norm_reg [3];
    logic [LIM_W-1:0]         limit_reg;
    logic                     inchunk_reg;
    logic                     rd_data_reg;

    logic                     res_valid_reg;
    logic [1:0]               res_status_reg;
    logic [3:0]               res_hit_reg [3];
    logic [1:0]               res_norm_reg [3];

    logic                     slot_free, is_write, wr_in_range, div_start;
    logic                     going, inchunk, hit, over_lim, step_go, res_load;
    logic [31:0]              wr_idx32, rd_idx32;
    logic [1:0]               ax;
    logic [T_W-1:0]           t_sel, t_new;
    logic [T_W:0]             t_sum;
    logic [2:0]               div_busy;
    logic [NUM_W-1:0]         quo_a [3];
    logic [NUM_W-1:0]         quo_b [3];
    logic [2:0]               norm_nz;

    // boundary-time dividers, one per axis
    for (genvar a = 0; a < 3; a++)
    begin : g_div
        vgrt_div u_div (
            .clk   (clk),
            .rst_n (rst_n),
            .start (div_start),
            .num_a ({item.axis[a].bnd_dist, {(NUM_W-DIST_W){1'b0}}}),
            .num_b (vgrt_pkg::NUM_STEP),
            .den   (item.axis[a].mag),
            .busy  (div_busy[a]),
            .quo_a (quo_a[a]),
            .quo_b (quo_b[a])
        );
    end

    // queue pop and dispatch
    always_comb
    begin
        slot_free   = !res_valid_reg || rsp.ready;
        is_write    = item.kind == vgrt_pkg::KIND_WRITE;
        wr_idx32    = 32'(item.voxel_index);
        wr_in_range = wr_idx32 < 32'(CELLS);
        item_pop    = (state_reg == S_IDLE) && item_valid
                   && (is_write || !item.zero_dir || slot_free);
        div_start   = item_pop && !is_write && !item.zero_dir;
    end

    // traversal tests and axis choice
    always_comb
    begin
        going   = 1'b1;
        inchunk = 1'b1;
        for (int a = 0; a < 3; a++)
        begin
            if (neg_reg[a] ? (cell_reg[a] < 0) : (cell_reg[a] >= GRID_HI))
                going = 1'b0;
            if (cell_reg[a] < 0 || cell_reg[a] >= GRID_HI)
                inchunk = 1'b0;
            norm_nz[a] = norm_reg[a] != vgrt_pkg::NORM_NONE;
        end
        rd_idx32 = 32'(cell_reg[0]) * 32'(GRID_SIZE * GRID_SIZE)
                 + 32'(cell_reg[1]) * 32'(GRID_SIZE) + 32'(cell_reg[2]);

        if (t_reg[0] < t_reg[1])
            ax = (t_reg[0] < t_reg[2]) ? AX_X : AX_Z;
        else
            ax = (t_reg[1] < t_reg[2]) ? AX_Y : AX_Z;

        t_sel    = t_reg[ax];
        over_lim = t_sel > T_W'(limit_reg);
        t_sum    = {1'b0, t_sel} + {1'b0, dt_reg[ax]};
        t_new    = t_sum[T_W] ? vgrt_pkg::T_SAT : t_sum[T_W-1:0];
        hit      = inchunk_reg && rd_data_reg;
        step_go  = (state_reg == S_CHECK) && !hit && !over_lim;
        // a result is loaded this cycle
        res_load = ((state_reg == S_IDLE) && item_pop && !is_write && item.zero_dir)
                || ((state_reg == S_READ) && !going && slot_free)
                || ((state_reg == S_CHECK) && (hit || over_lim) && slot_free);
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_cnt_reg    <= '0;
            res_valid_reg  <= 1'b0;
            res_status_reg <= vgrt_pkg::ST_HIT;
            limit_reg      <= '0;
            inchunk_reg    <= 1'b0;
            for (int a = 0; a < 3; a++)
            begin
                cell_reg[a]     <= '0;
                t_reg[a]        <= '0;
                dt_reg[a]       <= '0;
                neg_reg[a]      <= 1'b0;
                zero_reg[a]     <= 1'b0;
                norm_reg[a]     <= vgrt_pkg::NORM_NONE;
                res_hit_reg[a]  <= '0;
                res_norm_reg[a] <= vgrt_pkg::NORM_NONE;
            end
        end
        else
        begin
            if (res_valid_reg && rsp.ready && !res_load)
                res_valid_reg <= 1'b0;

            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == CLR_LAST)
                        state_reg <= S_IDLE;
                end

                S_IDLE:
                begin
                    if (item_pop && !is_write)
                    begin
                        if (item.zero_dir)
                        begin
                            res_valid_reg  <= 1'b1;
                            res_status_reg <= vgrt_pkg::ST_ZERO;
                            for (int a = 0; a < 3; a++)
                            begin
                                res_hit_reg[a]  <= '0;
                                res_norm_reg[a] <= vgrt_pkg::NORM_NONE;
                            end
                        end
                        else
                        begin
                            limit_reg <= {item.max_distance, 8'h00};
                            for (int a = 0; a < 3; a++)
                            begin
                                cell_reg[a] <= item.axis[a].start_cell;
                                neg_reg[a]  <= item.axis[a].neg;
                                zero_reg[a] <= item.axis[a].zero;
                                norm_reg[a] <= vgrt_pkg::NORM_NONE;
                            end
                            state_reg <= S_DIV;
                        end
                    end
                end

                S_DIV:
                begin
                    if (!div_busy[0])
                    begin
                        for (int a = 0; a < 3; a++)
                        begin
                            t_reg[a]  <= zero_reg[a] ? vgrt_pkg::T_SAT : T_W'(quo_a[a]);
                            dt_reg[a] <= zero_reg[a] ? vgrt_pkg::T_SAT : T_W'(quo_b[a]);
                        end
                        state_reg <= S_READ;
                    end
                end

                S_READ:
                begin
                    if (!going)
                    begin
                        // ray has passed the far side of the chunk
                        if (slot_free)
                        begin
                            res_valid_reg  <= 1'b1;
                            res_status_reg <= vgrt_pkg::ST_LEFT;
                            for (int a = 0; a < 3; a++)
                            begin
                                res_hit_reg[a]  <= '0;
                                res_norm_reg[a] <= norm_reg[a];
                            end
                            state_reg <= S_IDLE;
                        end
                    end
                    else
                    begin
                        inchunk_reg <= inchunk;
                        state_reg   <= S_CHECK;
                    end
                end

                S_CHECK:
                begin
                    if (hit)
                    begin
                        if (slot_free)
                        begin
                            res_valid_reg  <= 1'b1;
                            res_status_reg <= vgrt_pkg::ST_HIT;
                            for (int a = 0; a < 3; a++)
                            begin
                                res_hit_reg[a]  <= cell_reg[a][3:0];
                                res_norm_reg[a] <= norm_reg[a];
                            end
                            state_reg <= S_IDLE;
                        end
                    end
                    else if (over_lim)
                    begin
                        if (slot_free)
                        begin
                            res_valid_reg  <= 1'b1;
                            res_status_reg <= vgrt_pkg::ST_FAR;
                            for (int a = 0; a < 3; a++)
                            begin
                                res_hit_reg[a]  <= '0;
                                res_norm_reg[a] <= vgrt_pkg::NORM_NONE;
                            end
                            state_reg <= S_IDLE;
                        end
                    end
                    else
                    begin
                        // cross the nearest boundary
                        for (int a = 0; a < 3; a++)
                            norm_reg[a] <= (2'(a) == ax)
                                ? (neg_reg[ax] ? vgrt_pkg::NORM_POS : vgrt_pkg::NORM_NEG)
                                : vgrt_pkg::NORM_NONE;
                        cell_reg[ax] <= neg_reg[ax] ? cell_reg[ax] - CELL_W'(1)
                                                    : cell_reg[ax] + CELL_W'(1);
                        t_reg[ax]    <= t_new;
                        state_reg    <= S_READ;
                    end
                end

                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // occupancy map: clearing pass, writes, registered read
    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLEAR)
            solid_map[clr_cnt_reg] <= 1'b0;
        else if (item_pop && is_write && wr_in_range)
            solid_map[wr_idx32[AW-1:0]] <= item.solid;
        if (state_reg == S_READ)
            rd_data_reg <= solid_map[rd_idx32[AW-1:0]];
    end

    assign rsp.valid    = res_valid_reg;
    assign rsp.status   = res_status_reg;
    assign rsp.hit_x    = res_hit_reg[0];
    assign rsp.hit_y    = res_hit_reg[1];
    assign rsp.hit_z    = res_hit_reg[2];
    assign rsp.normal_x = res_norm_reg[0];
    assign rsp.normal_y = res_norm_reg[1];
    assign rsp.normal_z = res_norm_reg[2];

    `VGRT_ASSERT_IMP(a_no_pop_in_clear, state_reg == S_CLEAR, !item_pop)
    `VGRT_ASSERT_NXT(a_div_runs, div_start, div_busy[0] && state_reg == S_DIV)
    `VGRT_ASSERT_NXT(a_step_one_face, step_go, $onehot(norm_nz))

endmodule
